// ===== rtl/core/qte_pkg.sv =====
// ----------------------------------------------------------------------------
// qte_pkg: quaternion to euler angle shared types and constants
// Datapath widths, the cordic arctangent table and the square root step count.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int QW         = 16;   // quaternion part, q1.15
  localparam int PW         = 32;   // product of two parts
  localparam int MW         = 35;   // rotation matrix term, units of 2^-30
  localparam int SW         = 32;   // saturated pitch sine
  localparam int VW         = 61;   // square root radicand
  localparam int RW         = 62;   // square root partial root
  localparam int XW         = 37;   // cordic vector component
  localparam int ZW         = 34;   // cordic angle, degrees in units of 2^-24
  localparam int ACC_FRAC   = 24;
  localparam int TABLE_LEN  = 24;
  localparam int SQRT_STEPS = 31;

  localparam logic signed [ZW-1:0] Z180 = ZW'(64'sd180 <<< ACC_FRAC);

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cor_t;

  typedef struct packed {
    logic signed [MW-1:0] m11;
    logic signed [MW-1:0] m12;
    logic signed [MW-1:0] m23;
    logic signed [MW-1:0] m33;
    logic signed [SW-1:0] s;
  } side_t;

  // atan(2^-i) in degrees, units of 2^-24, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_deg(input int i);
    logic signed [ZW-1:0] t;
    case (i)
      0:  t = ZW'(754974720);
      1:  t = ZW'(445687602);
      2:  t = ZW'(235489089);
      3:  t = ZW'(119537938);
      4:  t = ZW'(60000934);
      5:  t = ZW'(30029717);
      6:  t = ZW'(15018523);
      7:  t = ZW'(7509720);
      8:  t = ZW'(3754917);
      9:  t = ZW'(1877466);
      10: t = ZW'(938734);
      11: t = ZW'(469367);
      12: t = ZW'(234684);
      13: t = ZW'(117342);
      14: t = ZW'(58671);
      15: t = ZW'(29335);
      16: t = ZW'(14668);
      17: t = ZW'(7334);
      18: t = ZW'(3667);
      19: t = ZW'(1833);
      20: t = ZW'(917);
      21: t = ZW'(458);
      22: t = ZW'(229);
      23: t = ZW'(115);
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/core/qte_if.sv =====
// ----------------------------------------------------------------------------
// qte_if: valid/ready channels of the quaternion to euler angle core
// Input channel carries one quaternion, output channel carries three angles.
// ----------------------------------------------------------------------------
interface qte_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_deg;
  logic signed [14:0] pitch_deg;
  logic        [15:0] yaw_deg;
  modport source (output valid, roll_deg, pitch_deg, yaw_deg, input ready);
  modport sink   (input valid, roll_deg, pitch_deg, yaw_deg, output ready);
endinterface

// ===== rtl/core/quaternion_to_euler_degrees_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_degrees_core: roll, pitch and yaw from a quaternion
// Pipeline stages: products, matrix terms, sine square, radicand, 31 square
// root steps, cordic setup, the cordic stages and output rounding. One word
// enters per cycle unless the output stalls; each stage holds its word only
// while the stage after it is full and stalled.
// Synchronous reset clears every stage valid bit; payload is not reset.
// ----------------------------------------------------------------------------
module quaternion_to_euler_degrees_core #(
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int CORDIC_STAGES   = 16
) (
  input  logic     clk,
  input  logic     rst,
  qte_in_if.sink   quat_in,
  qte_out_if.source angle_out
);
  import qte_pkg::*;

  localparam int ST_PROD = 0;
  localparam int ST_M    = 1;
  localparam int ST_SQ   = 2;
  localparam int ST_V    = 3;
  localparam int ST_SQRT = 4;
  localparam int ST_PRE  = ST_SQRT + SQRT_STEPS;
  localparam int ST_COR  = ST_PRE + 1;
  localparam int ST_OUT  = ST_COR + CORDIC_STAGES;
  localparam int N       = ST_OUT + 1;
  localparam int SH      = ACC_FRAC - ANGLE_FRAC_BITS;

  localparam logic signed [ZW-1:0] RND  = ZW'(64'sd1 <<< (SH - 1));
  localparam logic signed [ZW-1:0] D90  = ZW'(64'sd90 <<< ANGLE_FRAC_BITS);
  localparam logic signed [ZW-1:0] D180 = ZW'(64'sd180 <<< ANGLE_FRAC_BITS);
  localparam logic signed [ZW-1:0] D360 = ZW'(64'sd360 <<< ANGLE_FRAC_BITS);
  localparam logic signed [SW-1:0] ONE  = SW'(64'sd1 <<< 30);

  logic [N-1:0] vld;
  logic [N:0]   en;

  assign en[N]         = angle_out.ready;
  assign quat_in.ready = en[0];
  assign angle_out.valid = vld[N-1];

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_ctl
      assign en[k] = ~vld[k] | en[k+1];
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (en[k]) begin
          if (k == 0) vld[k] <= quat_in.valid;
          else        vld[k] <= vld[(k == 0) ? 0 : k-1];
        end
      end
    end
  endgenerate

  // products
  logic signed [PW-1:0] p_ww, p_xx, p_zz, p_xy, p_wz, p_xz, p_wy, p_yz, p_wx;
  always_ff @(posedge clk) begin
    if (en[ST_PROD]) begin
      p_ww <= quat_in.quat_w * quat_in.quat_w;
      p_xx <= quat_in.quat_x * quat_in.quat_x;
      p_zz <= quat_in.quat_z * quat_in.quat_z;
      p_xy <= quat_in.quat_x * quat_in.quat_y;
      p_wz <= quat_in.quat_w * quat_in.quat_z;
      p_xz <= quat_in.quat_x * quat_in.quat_z;
      p_wy <= quat_in.quat_w * quat_in.quat_y;
      p_yz <= quat_in.quat_y * quat_in.quat_z;
      p_wx <= quat_in.quat_w * quat_in.quat_x;
    end
  end

  // matrix terms and saturated pitch sine
  side_t                m_reg;
  logic signed [MW-1:0] m11_c, m12_c, m13_c, m23_c, m33_c, nm13;
  logic signed [SW-1:0] s_c;
  always_comb begin
    m11_c = ((MW'(p_ww) + MW'(p_xx)) <<< 1) - MW'(ONE);
    m33_c = ((MW'(p_ww) + MW'(p_zz)) <<< 1) - MW'(ONE);
    m12_c = (MW'(p_xy) + MW'(p_wz)) <<< 1;
    m13_c = (MW'(p_xz) - MW'(p_wy)) <<< 1;
    m23_c = (MW'(p_yz) + MW'(p_wx)) <<< 1;
    nm13  = -m13_c;
    if (nm13 > MW'(ONE))       s_c = ONE;
    else if (nm13 < -MW'(ONE)) s_c = -ONE;
    else                       s_c = SW'(nm13);
  end
  always_ff @(posedge clk) begin
    if (en[ST_M]) begin
      m_reg <= '{m11: m11_c, m12: m12_c, m23: m23_c, m33: m33_c, s: s_c};
    end
  end

  // sine squared
  side_t          sq_side;
  logic [VW-1:0]  sq;
  logic signed [2*SW-1:0] sq_full;
  assign sq_full = m_reg.s * m_reg.s;
  always_ff @(posedge clk) begin
    if (en[ST_SQ]) begin
      sq_side <= m_reg;
      sq      <= sq_full[VW-1:0];
    end
  end

  // square root: radicand then one result bit per stage
  side_t         sd [SQRT_STEPS+1];
  logic [VW-1:0] sv [SQRT_STEPS+1];
  logic [RW-1:0] sr [SQRT_STEPS+1];
  always_ff @(posedge clk) begin
    if (en[ST_V]) begin
      sd[0] <= sq_side;
      sv[0] <= (VW'(1) << 60) - sq;
      sr[0] <= '0;
    end
  end

  generate
    for (k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [RW:0] BIT = (RW+1)'(1) << (60 - 2*k);
      logic [RW:0] trial;
      assign trial = {1'b0, sr[k]} + BIT;
      always_ff @(posedge clk) begin
        if (en[ST_SQRT+k]) begin
          sd[k+1] <= sd[k];
          if ({2'b00, sv[k]} >= trial) begin
            sv[k+1] <= sv[k] - VW'(trial);
            sr[k+1] <= (sr[k] >> 1) + RW'(BIT);
          end else begin
            sv[k+1] <= sv[k];
            sr[k+1] <= sr[k] >> 1;
          end
        end
      end
    end
  endgenerate

  // cordic setup: fold left half plane onto the right
  function automatic cor_t cor_init(input logic signed [XW-1:0] y,
                                    input logic signed [XW-1:0] x);
    cor_t r;
    if (x < 0) begin
      r.x = -x;
      r.y = -y;
      r.z = (y >= 0) ? Z180 : -Z180;
    end else begin
      r.x = x;
      r.y = y;
      r.z = '0;
    end
    return r;
  endfunction

  cor_t cr [CORDIC_STAGES+1];
  cor_t cp [CORDIC_STAGES+1];
  cor_t cy [CORDIC_STAGES+1];
  always_ff @(posedge clk) begin
    if (en[ST_PRE]) begin
      cr[0] <= cor_init(XW'(sd[SQRT_STEPS].m23), XW'(sd[SQRT_STEPS].m33));
      cp[0] <= cor_init(XW'(sd[SQRT_STEPS].s), XW'(sr[SQRT_STEPS][30:0]));
      cy[0] <= cor_init(XW'(sd[SQRT_STEPS].m12), XW'(sd[SQRT_STEPS].m11));
    end
  end

  function automatic cor_t cor_step(input cor_t a, input int i);
    cor_t r;
    if (a.y > 0) begin
      r.x = a.x + (a.y >>> i);
      r.y = a.y - (a.x >>> i);
      r.z = a.z + atan_deg(i);
    end else if (a.y < 0) begin
      r.x = a.x - (a.y >>> i);
      r.y = a.y + (a.x >>> i);
      r.z = a.z - atan_deg(i);
    end else begin
      r = a;
    end
    return r;
  endfunction

  generate
    for (k = 0; k < CORDIC_STAGES; k++) begin : g_cor
      always_ff @(posedge clk) begin
        if (en[ST_COR+k]) begin
          cr[k+1] <= cor_step(cr[k], k);
          cp[k+1] <= cor_step(cp[k], k);
          cy[k+1] <= cor_step(cy[k], k);
        end
      end
    end
  endgenerate

  // round half up, clamp roll and pitch, wrap yaw
  logic signed [ZW-1:0] roll_r, pitch_r, yaw_r, yaw_a, yaw_b;
  logic signed [ZW-1:0] roll_c, pitch_c;
  always_comb begin
    roll_r  = (cr[CORDIC_STAGES].z + RND) >>> SH;
    pitch_r = (cp[CORDIC_STAGES].z + RND) >>> SH;
    yaw_r   = (cy[CORDIC_STAGES].z + RND) >>> SH;
    if (roll_r > D180)       roll_c = D180;
    else if (roll_r < -D180) roll_c = -D180;
    else                     roll_c = roll_r;
    if (pitch_r > D90)       pitch_c = D90;
    else if (pitch_r < -D90) pitch_c = -D90;
    else                     pitch_c = pitch_r;
    yaw_a = (yaw_r < 0) ? yaw_r + D360 : yaw_r;
    yaw_b = (yaw_a >= D360) ? yaw_a - D360 : yaw_a;
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      angle_out.roll_deg  <= roll_c[15:0];
      angle_out.pitch_deg <= pitch_c[14:0];
      angle_out.yaw_deg   <= yaw_b[15:0];
    end
  end

endmodule

// ===== rtl/core/qte_checker.sv =====
// ----------------------------------------------------------------------------
// qte_checker: port level checks of the quaternion to euler angle core
// Watches the output channel for reset, hold and angle range behavior.
// ----------------------------------------------------------------------------
module qte_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] roll_deg,
  input logic signed [14:0] pitch_deg,
  input logic        [15:0] yaw_deg
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(roll_deg)
      && $stable(pitch_deg) && $stable(yaw_deg))
    else $error("stalled output word changed");

  a_roll: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> roll_deg >= -16'sd23040 && roll_deg <= 16'sd23040)
    else $error("roll out of range");

  a_pitch_yaw: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pitch_deg >= -15'sd11520 && pitch_deg <= 15'sd11520
      && yaw_deg < 16'd46080)
    else $error("pitch or yaw out of range");

endmodule

bind quaternion_to_euler_degrees_core qte_checker u_qte_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (angle_out.valid),
  .out_ready (angle_out.ready),
  .roll_deg  (angle_out.roll_deg),
  .pitch_deg (angle_out.pitch_deg),
  .yaw_deg   (angle_out.yaw_deg)
);

// ===== sim/quaternion_to_euler_degrees_core_test.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_degrees_core_test: self-checking bench for the core
// Drives quaternions through the input channel with random gaps and stalls,
// predicts roll, pitch and yaw in fixed point and checks every output word.
// ----------------------------------------------------------------------------
module quaternion_to_euler_degrees_core_test;

  import qte_pkg::*;

  localparam int FRAC      = 7;
  localparam int STAGES    = 16;
  localparam int LATENCY   = 37 + STAGES;
  localparam int N_RANDOM  = 950;
  localparam int MAX_CYCLE = 400000;

  typedef struct {
    logic [15:0] roll;
    logic [14:0] pitch;
    logic [15:0] yaw;
  } angles_t;

  class angle_scoreboard;
    angles_t pending[$];
    int      errors;
    int      matched;

    function longint isqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return longint'(res);
    endfunction

    // vectoring cordic, result in degrees * 2^24
    function longint vector_angle(longint yv, longint xv);
      longint acc, nx, ny;
      acc = 0;
      if (xv == 0 && yv == 0) return 0;
      if (xv < 0) begin
        acc = (yv >= 0) ? (longint'(180) <<< ACC_FRAC) : -(longint'(180) <<< ACC_FRAC);
        xv = -xv;
        yv = -yv;
      end
      for (int i = 0; i < STAGES && i < TABLE_LEN; i++) begin
        nx = xv;
        ny = yv;
        if (yv > 0) begin
          nx = xv + (yv >>> i);
          ny = yv - (xv >>> i);
          acc += longint'(atan_deg(i));
        end else if (yv < 0) begin
          nx = xv - (yv >>> i);
          ny = yv + (xv >>> i);
          acc -= longint'(atan_deg(i));
        end
        xv = nx;
        yv = ny;
      end
      return acc;
    endfunction

    function longint round_out(longint a);
      return (a + (longint'(1) <<< (ACC_FRAC - FRAC - 1))) >>> (ACC_FRAC - FRAC);
    endfunction

    function void note(logic signed [15:0] qw, logic signed [15:0] qx,
                       logic signed [15:0] qy, logic signed [15:0] qz);
      longint w, x, y, z, unit, m11, m12, m13, m23, m33, s, c, r, p, yw;
      angles_t e;
      w = qw; x = qx; y = qy; z = qz;
      unit = longint'(1) <<< 30;
      m11 = 2 * (w * w + x * x) - unit;
      m12 = 2 * (x * y + w * z);
      m13 = 2 * (x * z - w * y);
      m23 = 2 * (y * z + w * x);
      m33 = 2 * (w * w + z * z) - unit;
      r = round_out(vector_angle(m23, m33));
      if (r > (180 <<< FRAC)) r = 180 <<< FRAC;
      if (r < -(180 <<< FRAC)) r = -(180 <<< FRAC);
      // pitch sine saturated to [-1, 1]
      s = -m13;
      if (s > unit) s = unit;
      if (s < -unit) s = -unit;
      c = isqrt(longint'((longint'(1) <<< 60) - s * s));
      p = round_out(vector_angle(s, c));
      if (p > (90 <<< FRAC)) p = 90 <<< FRAC;
      if (p < -(90 <<< FRAC)) p = -(90 <<< FRAC);
      yw = round_out(vector_angle(m12, m11));
      if (yw < 0) yw += 360 <<< FRAC;
      if (yw >= (360 <<< FRAC)) yw -= 360 <<< FRAC;
      e.roll  = r[15:0];
      e.pitch = p[14:0];
      e.yaw   = yw[15:0];
      pending.push_back(e);
    endfunction

    function void check(logic [15:0] roll, logic [14:0] pitch, logic [15:0] yaw);
      angles_t e;
      if (pending.size() == 0) begin
        $error("output word with no quaternion pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (roll !== e.roll) begin
        $error("roll_deg expected %0d got %0d", $signed(e.roll), $signed(roll));
        errors++;
      end
      if (pitch !== e.pitch) begin
        $error("pitch_deg expected %0d got %0d", $signed(e.pitch), $signed(pitch));
        errors++;
      end
      if (yaw !== e.yaw) begin
        $error("yaw_deg expected %0d got %0d", e.yaw, yaw);
        errors++;
      end
      matched++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #10 clk = ~clk;

  qte_in_if  in_ch ();
  qte_out_if out_ch ();

  quaternion_to_euler_degrees_core #(
    .ANGLE_FRAC_BITS(FRAC),
    .CORDIC_STAGES  (STAGES)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .quat_in  (in_ch),
    .angle_out(out_ch)
  );

  angle_scoreboard sb = new();
  int  sent;
  int  cycles;
  bit  send_done;

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.quat_w = '0;
    in_ch.quat_x = '0;
    in_ch.quat_y = '0;
    in_ch.quat_z = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("quaternion_to_euler_degrees_core_test: FAIL");
      $finish;
    end
  end

  // gap per word, with stretches of back-to-back traffic
  function int draw_gap(int n);
    if ((n / 64) % 3 == 1) return 0;
    return $urandom_range(0, 14);
  endfunction

  task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z);
    int gap;
    gap = draw_gap(sent);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.quat_w <= w;
    in_ch.quat_x <= x;
    in_ch.quat_y <= y;
    in_ch.quat_z <= z;
    do @(posedge clk); while (!in_ch.ready);
    sb.note(w, x, y, z);
    sent++;
  endtask

  function logic signed [15:0] near_unit_part();
    case ($urandom_range(0, 3))
      0: return 16'($signed($urandom_range(0, 65535)));
      1: return 16'($signed($urandom_range(0, 2000)) - 1000);
      2: return 16'sd23170;
      default: return 16'($signed($urandom_range(0, 46340)) - 23170);
    endcase
  endfunction

  task automatic directed_words();
    send_quat(16'sd32767, 16'sd0, 16'sd0, 16'sd0);          // identity
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);              // all parts zero
    send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_quat(16'sd23170, 16'sd0, 16'sd23170, 16'sd0);      // pitch +90
    send_quat(16'sd23170, 16'sd0, -16'sd23170, 16'sd0);     // pitch -90
    send_quat(16'sd32767, 16'sd0, 16'sd32767, 16'sd0);      // sine saturates
    send_quat(16'sd32767, 16'sd0, -16'sd32767, 16'sd0);
    send_quat(16'sd0, 16'sd32767, 16'sd0, 16'sd0);          // roll at 180
    send_quat(16'sd0, -16'sd32768, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd32767);          // yaw at 180
    send_quat(16'sd32767, 16'sd0, 16'sd0, -16'sd1);         // yaw just below 0
    send_quat(16'sd32767, 16'sd0, 16'sd0, 16'sd1);
    send_quat(16'sd23170, 16'sd0, 16'sd0, -16'sd23170);     // yaw 270
    send_quat(16'sd0, 16'sd23170, 16'sd23170, 16'sd0);      // negative x with y zero
    send_quat(16'sd0, 16'sd32767, -16'sd1, 16'sd0);         // roll at 180, yaw just below 0
    send_quat(16'sd0, 16'sd32767, 16'sd1, 16'sd0);
    send_quat(16'sd1, 16'sd0, 16'sd0, 16'sd0);              // tiny, not normalized
    send_quat(-16'sd1, 16'sd1, -16'sd1, 16'sd1);
    send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
    send_quat(16'sh5555, -16'sh5556, 16'sh2AAA, -16'sh2AAB); // alternating bits
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_words();
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 1))
        send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      else
        send_quat(near_unit_part(), near_unit_part(), near_unit_part(), near_unit_part());
    end
    in_ch.valid <= 1'b0;
    send_done = 1'b1;
  end

  // output side: random stalls, one long hold-off to back the pipe up
  initial begin
    int stall;
    int got;
    got = 0;
    @(negedge rst);
    forever begin
      if (got == 150) begin
        out_ch.ready <= 1'b0;
        repeat (20 * LATENCY) @(posedge clk);
      end
      stall = ((got / 80) % 3 == 2) ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check(out_ch.roll_deg, out_ch.pitch_deg, out_ch.yaw_deg);
      got++;
    end
  end

  initial begin
    wait (send_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    $display("covered %0d quaternions: axis extremes, gimbal lock, saturation, yaw wrap",
             sent);
    $display("%0d angle words checked, %0d mismatches", sb.matched, sb.errors);
    if (sb.errors == 0)
      $display("quaternion_to_euler_degrees_core_test: PASS");
    else
      $display("quaternion_to_euler_degrees_core_test: FAIL");
    $finish;
  end

endmodule
